// ===== sv/vcs_pkg.sv =====
package vcs_pkg;

   // Injector count and counter width.
   localparam int NUM_INJECTORS = 4;
   localparam int INJ_MAX       = 4;
   localparam int INJ_USED      = (NUM_INJECTORS < INJ_MAX) ? NUM_INJECTORS : INJ_MAX;
   localparam int COUNT_BITS    = 16;

   // Register layout.
   localparam int FIELD_BITS      = 16;
   localparam int INJ_TIMING_BITS = 48;
   localparam int FILT_TIMING_BITS = 64;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int FILT_VALVES     = 3;
   localparam int PHASE_BITS      = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_INJ_A_TIMING  = 3'd0,
      CSR_INJ_B_TIMING  = 3'd1,
      CSR_INJ_C_TIMING  = 3'd2,
      CSR_INJ_D_TIMING  = 3'd3,
      CSR_FILT_TIMING   = 3'd4,
      CSR_FILT_ENABLE   = 3'd5
   } csr_index_type;

   // Filtration phases, numbered as they appear on the result word.
   typedef enum logic [PHASE_BITS-1:0] {
      PH_FIRST_DELAY = 3'd1,
      PH_VALVE0_ON   = 3'd2,
      PH_DELAY_V1    = 3'd3,
      PH_VALVE1_ON   = 3'd4,
      PH_DELAY_V2    = 3'd5,
      PH_VALVE2_ON   = 3'd6,
      PH_PAUSE       = 3'd7
   } phase_type;

   // Counters of one injector, as held in the state memory.
   typedef struct packed {
      logic [COUNT_BITS-1:0] on_cnt;
      logic [COUNT_BITS-1:0] off_cnt;
      logic [COUNT_BITS-1:0] cyc_cnt;
   } inj_cnt_type;

   // One memory row carries the counters of every injector.
   typedef inj_cnt_type [INJ_USED-1:0] inj_row_type;

   typedef struct packed {
      logic        open;
      inj_cnt_type cnt;
   } inj_lane_type;

   // Control from the top level to the filtration sequencer.
   typedef struct packed {
      logic step;
      logic enable;
   } filt_ctrl_type;

   // State of the filtration sequencer after the current tick.
   typedef struct packed {
      logic [FILT_VALVES-1:0] valves;
      phase_type              phase;
   } filt_status_type;

   // One tick of a single injector while fertigation runs.
   function automatic inj_lane_type inj_step(inj_lane_type cur,
                                             logic [INJ_TIMING_BITS-1:0] timing);
      logic [COUNT_BITS-1:0] on_per;
      logic [COUNT_BITS-1:0] off_per;
      logic [COUNT_BITS-1:0] budget;
      inj_lane_type          nxt;
      on_per  = timing[0*FIELD_BITS +: COUNT_BITS];
      off_per = timing[1*FIELD_BITS +: COUNT_BITS];
      budget  = timing[2*FIELD_BITS +: COUNT_BITS];
      nxt     = cur;
      if (cur.open) begin
         if (cur.cnt.on_cnt == on_per) begin
            nxt.open        = 1'b0;
            nxt.cnt.on_cnt  = '0;
            nxt.cnt.off_cnt = cur.cnt.off_cnt + 1'b1;
            nxt.cnt.cyc_cnt = cur.cnt.cyc_cnt + 1'b1;
         end else begin
            nxt.cnt.on_cnt  = cur.cnt.on_cnt + 1'b1;
         end
      end else if (cur.cnt.off_cnt == off_per) begin
         // Reopen only while the cycle budget lasts; otherwise the off count holds.
         if (cur.cnt.cyc_cnt < budget) begin
            nxt.open        = 1'b1;
            nxt.cnt.on_cnt  = cur.cnt.on_cnt + 1'b1;
            nxt.cnt.off_cnt = '0;
         end
      end else begin
         nxt.cnt.off_cnt = cur.cnt.off_cnt + 1'b1;
      end
      return nxt;
   endfunction

endpackage

// ===== sv/vcs_filt_seq.sv =====
module vcs_filt_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  vcs_pkg::filt_ctrl_type           ctrl,
   input  logic [vcs_pkg::FILT_TIMING_BITS-1:0] timing,
   output vcs_pkg::filt_status_type         status_next
);
   import vcs_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [COUNT_BITS-1:0]  tick_ff, tick_in;
   logic [FILT_VALVES-1:0] valves_ff, valves_in;

   logic [COUNT_BITS-1:0]  tick_inc;
   logic [COUNT_BITS-1:0]  target;
   logic [FILT_VALVES-1:0] open_next;
   phase_type              phase_adv;
   logic                   known;

   // State register; the sequence moves only when a word passes the update stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST_DELAY;
         tick_ff   <= '0;
         valves_ff <= '0;
      end else if (ctrl.step) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         valves_ff <= valves_in;
      end
   end

   // Target, valve action and successor of the current phase.
   always_comb begin
      known     = 1'b1;
      target    = '0;
      open_next = valves_ff;
      phase_adv = phase_ff;
      case (phase_ff)
         PH_FIRST_DELAY: begin
            target       = timing[0*FIELD_BITS +: COUNT_BITS];
            open_next[0] = 1'b1;
            phase_adv    = PH_VALVE0_ON;
         end
         PH_VALVE0_ON: begin
            target       = timing[1*FIELD_BITS +: COUNT_BITS];
            open_next[0] = 1'b0;
            phase_adv    = PH_DELAY_V1;
         end
         PH_DELAY_V1: begin
            target       = timing[2*FIELD_BITS +: COUNT_BITS];
            open_next[1] = 1'b1;
            phase_adv    = PH_VALVE1_ON;
         end
         PH_VALVE1_ON: begin
            target       = timing[1*FIELD_BITS +: COUNT_BITS];
            open_next[1] = 1'b0;
            phase_adv    = PH_DELAY_V2;
         end
         PH_DELAY_V2: begin
            target       = timing[2*FIELD_BITS +: COUNT_BITS];
            open_next[2] = 1'b1;
            phase_adv    = PH_VALVE2_ON;
         end
         PH_VALVE2_ON: begin
            target       = timing[1*FIELD_BITS +: COUNT_BITS];
            open_next[2] = 1'b0;
            phase_adv    = PH_PAUSE;
         end
         PH_PAUSE: begin
            target       = timing[3*FIELD_BITS +: COUNT_BITS];
            phase_adv    = PH_FIRST_DELAY;
         end
         default: begin
            known        = 1'b0;
         end
      endcase
   end

   // Next state: count the tick while enabled (else clear it), and step the phase when its target is reached.
   always_comb begin
      tick_inc  = tick_ff + 1'b1;
      tick_in   = tick_inc;
      phase_in  = phase_ff;
      valves_in = valves_ff;
      if (!ctrl.enable) begin
         tick_in = '0;
      end else if (known && (tick_inc == target)) begin
         tick_in   = '0;
         valves_in = open_next;
         phase_in  = phase_adv;
      end
      status_next.valves = valves_in;
      status_next.phase  = phase_in;
   end

endmodule

// ===== sv/valve_cycle_sequencer_core.sv =====
// A request word passes the update stage and then the output register before its result word is presented.
// Throughput: one request word per cycle while the result side does not stall; the single-row
// counter memory is read at acceptance and written back as the word leaves the update
// stage, with forwarding for back-to-back words.
// Reset is synchronous and active high; it closes every valve, returns the filtration
// sequence to its first phase and clears the configuration and control registers. The counter memory needs no
// clearing pass: a row-valid flag makes it read as zero until first written.
module valve_cycle_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_fertigation_on,
   input  logic                              req_start_fertigation,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [3:0]                        rsp_injector_valves,
   output logic [vcs_pkg::FILT_VALVES-1:0]   rsp_filtration_valves,
   output logic [vcs_pkg::PHASE_BITS-1:0]    rsp_filtration_phase,
   input  logic                              csr_write_enable,
   input  logic [vcs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [vcs_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import vcs_pkg::*;

   // Configuration registers.
   logic [INJ_TIMING_BITS-1:0]  inj_timing_ff [INJ_MAX];
   logic [FILT_TIMING_BITS-1:0] filt_timing_ff;
   logic                        filt_enable_ff;

   // Update stage and forwarding.
   logic                 s1_valid_ff;
   logic                 s1_fert_ff;
   logic                 s1_start_ff;
   logic                 row_valid_ff;
   logic                 rd_valid_ff;
   logic                 fwd_sel_ff;
   inj_row_type          rd_row_ff;
   inj_row_type          fwd_row_ff;
   inj_row_type          inj_mem [0:0];
   logic [INJ_USED-1:0]  inj_open_ff, inj_open_in;

   inj_row_type          cur_row;
   inj_row_type          row_in;
   inj_lane_type         lane_cur [INJ_USED];
   inj_lane_type         lane_nxt [INJ_USED];

   // Output register.
   logic                   rsp_valid_ff;
   logic [3:0]             rsp_inj_ff;
   logic [3:0]             inj_word;
   logic [FILT_VALVES-1:0] rsp_filt_ff;
   logic [PHASE_BITS-1:0]  rsp_phase_ff;

   logic            req_accept;
   logic            s1_adv;
   filt_ctrl_type   filt_ctrl;
   filt_status_type filt_next;

   // Handshake: the update stage moves on whenever the output register is free.
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < INJ_MAX; i++) begin
            inj_timing_ff[i] <= '0;
         end
         filt_timing_ff <= '0;
         filt_enable_ff <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_INJ_A_TIMING: inj_timing_ff[0] <= csr_wdata[INJ_TIMING_BITS-1:0];
            CSR_INJ_B_TIMING: inj_timing_ff[1] <= csr_wdata[INJ_TIMING_BITS-1:0];
            CSR_INJ_C_TIMING: inj_timing_ff[2] <= csr_wdata[INJ_TIMING_BITS-1:0];
            CSR_INJ_D_TIMING: inj_timing_ff[3] <= csr_wdata[INJ_TIMING_BITS-1:0];
            CSR_FILT_TIMING:  filt_timing_ff   <= csr_wdata[FILT_TIMING_BITS-1:0];
            CSR_FILT_ENABLE:  filt_enable_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Update stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         row_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         fwd_sel_ff   <= 1'b0;
         inj_open_ff  <= '0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
            rd_valid_ff <= row_valid_ff;
            fwd_sel_ff  <= s1_adv;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            row_valid_ff <= 1'b1;
            inj_open_ff  <= inj_open_in;
         end
      end
   end

   // Request word capture and forwarding copy of the row being written.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_fert_ff  <= req_fertigation_on;
         s1_start_ff <= req_start_fertigation;
      end
      if (s1_adv) begin
         fwd_row_ff <= row_in;
      end
   end

   // Counter memory: read when a word is accepted, written back when it leaves.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_row_ff <= inj_mem[0];
      end
      if (s1_adv) begin
         inj_mem[0] <= row_in;
      end
   end

   // Pick the current row: a write at the read edge wins over the memory data.
   always_comb begin
      if (fwd_sel_ff) begin
         cur_row = fwd_row_ff;
      end else if (rd_valid_ff) begin
         cur_row = rd_row_ff;
      end else begin
         cur_row = '0;
      end
   end

   // Injector lanes: start request, normal tick, or hold.
   always_comb begin
      for (int i = 0; i < INJ_USED; i++) begin
         lane_cur[i].open = inj_open_ff[i];
         lane_cur[i].cnt  = cur_row[i];
         lane_nxt[i]      = inj_step(lane_cur[i], inj_timing_ff[i]);
         if (s1_start_ff) begin
            row_in[i]      = '0;
            inj_open_in[i] = 1'b1;
         end else if (s1_fert_ff) begin
            row_in[i]      = lane_nxt[i].cnt;
            inj_open_in[i] = lane_nxt[i].open;
         end else begin
            row_in[i]      = cur_row[i];
            inj_open_in[i] = inj_open_ff[i];
         end
      end
   end

   // Filtration sequencer steps with every word that leaves the update stage.
   assign filt_ctrl.step   = s1_adv;
   assign filt_ctrl.enable = filt_enable_ff;

   vcs_filt_seq u_filt_seq (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (filt_ctrl),
      .timing      (filt_timing_ff),
      .status_next (filt_next)
   );

   // Injector valve bits, unused positions closed.
   always_comb begin
      inj_word                 = '0;
      inj_word[INJ_USED-1:0]   = inj_open_in;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_inj_ff   <= inj_word;
         rsp_filt_ff  <= filt_next.valves;
         rsp_phase_ff <= filt_next.phase;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_injector_valves   = rsp_inj_ff;
   assign rsp_filtration_valves = rsp_filt_ff;
   assign rsp_filtration_phase  = rsp_phase_ff;

endmodule

// ===== sv/vcs_checker.sv =====
module vcs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [3:0]                        rsp_injector_valves,
   input logic [vcs_pkg::FILT_VALVES-1:0]   rsp_filtration_valves,
   input logic [vcs_pkg::PHASE_BITS-1:0]    rsp_filtration_phase
);
   import vcs_pkg::*;

   // A stalled result word stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_injector_valves)
         && $stable(rsp_filtration_valves) && $stable(rsp_filtration_phase))
      else $error("stalled result word changed");

   // The input side is held back only while a finished result waits.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a waiting result");

   // Each phase goes with one fixed pattern of filtration valves.
   a_phase_valves: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_filtration_phase == PH_FIRST_DELAY && rsp_filtration_valves == 3'b000) ||
         (rsp_filtration_phase == PH_VALVE0_ON   && rsp_filtration_valves == 3'b001) ||
         (rsp_filtration_phase == PH_DELAY_V1    && rsp_filtration_valves == 3'b000) ||
         (rsp_filtration_phase == PH_VALVE1_ON   && rsp_filtration_valves == 3'b010) ||
         (rsp_filtration_phase == PH_DELAY_V2    && rsp_filtration_valves == 3'b000) ||
         (rsp_filtration_phase == PH_VALVE2_ON   && rsp_filtration_valves == 3'b100) ||
         (rsp_filtration_phase == PH_PAUSE       && rsp_filtration_valves == 3'b000))
      else $error("filtration valves disagree with phase");

   // A word accepted into a free pipe shows up as a result once it has passed the update stage and the output register.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> ##1 rsp_valid)
      else $error("result word did not appear");

endmodule

bind valve_cycle_sequencer_core vcs_checker u_vcs_checker (.*);
